>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; they expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/core/pbnp_pkg.sv
// Shared types and constants of the branch next-address block.
package pbnp_pkg;

  // Address width; every address wraps modulo 2^WORD_BITS (range 32 to 64).
  localparam int unsigned WORD_BITS = 64;

  typedef logic [WORD_BITS-1:0] addr_t;

  // Primary opcodes.
  localparam logic [5:0] OPC_B  = 6'd18;
  localparam logic [5:0] OPC_BC = 6'd16;
  localparam logic [5:0] OPC_XL = 6'd19;

  // Extended opcodes of the XL form.
  localparam logic [9:0] XO_BCLR  = 10'd16;
  localparam logic [9:0] XO_BCCTR = 10'd528;

  // Displacement field masks.
  localparam logic [31:0] B_DISP_MASK  = 32'h03fffffc;
  localparam logic [31:0] BC_DISP_MASK = 32'h0000fffc;

  typedef enum logic [2:0] {
    KIND_SEQ   = 3'd0,
    KIND_IFORM = 3'd1,
    KIND_BFORM = 3'd2,
    KIND_LINK  = 3'd3,
    KIND_COUNT = 3'd4
  } branch_kind_t;

  // One resolved result beat.
  typedef struct packed {
    logic [63:0]  next_pc;
    logic         redirected;
    branch_kind_t kind;
  } res_t;

endpackage

>>> rtl/core/pbnp_resolve.sv
// Combinational next-address resolution for one instruction.
module pbnp_resolve (
  input  logic [31:0]   instruction,
  input  logic [63:0]   current_pc,
  input  logic [63:0]   count_reg,
  input  logic [31:0]   cond_reg,
  input  logic [63:0]   link_reg,
  output pbnp_pkg::res_t res
);
  import pbnp_pkg::*;

  logic [5:0]   op;
  logic [9:0]   xo;
  logic [4:0]   bo;
  logic [4:0]   bi;
  logic         ctr_ok;
  logic         cr_ok;
  logic         cond;
  logic [31:0]  b_field;
  logic [31:0]  bc_field;
  addr_t        pc;
  addr_t        b_disp;
  addr_t        bc_disp;
  addr_t        b_target;
  addr_t        bc_target;
  addr_t        next_addr;
  branch_kind_t kind;

  // Field extraction.
  assign op = instruction[31:26];
  assign xo = instruction[10:1];
  assign bo = instruction[25:21];
  assign bi = instruction[20:16];
  assign pc = current_pc[WORD_BITS-1:0];

  // Branch condition: the count test uses CTR minus one on its low word.
  assign ctr_ok = bo[2] || ((count_reg[31:0] == 32'd1) == bo[1]);
  assign cr_ok  = bo[4] || (cond_reg[5'd31 - bi] == bo[3]);
  assign cond   = ctr_ok && cr_ok;

  // Sign-extended displacements and targets, absolute when AA is set.
  assign b_field   = instruction & B_DISP_MASK;
  assign bc_field  = instruction & BC_DISP_MASK;
  assign b_disp    = {{(WORD_BITS-26){b_field[25]}}, b_field[25:0]};
  assign bc_disp   = {{(WORD_BITS-16){bc_field[15]}}, bc_field[15:0]};
  assign b_target  = instruction[1] ? b_disp : pc + b_disp;
  assign bc_target = instruction[1] ? bc_disp : pc + bc_disp;

  // Opcode decode selects the next address.
  always_comb begin
    next_addr = pc + addr_t'(4);
    kind      = KIND_SEQ;
    unique case (op)
      OPC_B: begin
        next_addr = b_target;
        kind      = KIND_IFORM;
      end
      OPC_BC: begin
        if (cond) begin
          next_addr = bc_target;
          kind      = KIND_BFORM;
        end
      end
      OPC_XL: begin
        if (cond && xo == XO_BCLR) begin
          next_addr = {link_reg[WORD_BITS-1:2], 2'b00};
          kind      = KIND_LINK;
        end else if (cond && xo == XO_BCCTR) begin
          next_addr = {count_reg[WORD_BITS-1:2], 2'b00};
          kind      = KIND_COUNT;
        end
      end
      default: begin
      end
    endcase
  end

  // Addresses carry zeros above the word width.
  assign res.next_pc    = 64'(next_addr);
  assign res.redirected = (kind != KIND_SEQ);
  assign res.kind       = kind;

endmodule

>>> rtl/core/powerpc_branch_next_pc.sv
// Top level of the branch next-address block: input register, decode, result register.
//
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  instruction, current_pc, count_reg, cond_reg, link_reg
//  out      out_valid/out_stall  next_pc, redirected, branch_kind
//
// One beat in and one beat out per cycle while the output does not stall; a taken beat passes
// through the input register and then the result register before it reaches the outputs.
// The decode and the target adders sit between the input register and the result register.
// Reset clears both valid flags; payload registers are not reset.
// A stall on a valid output holds the result register and, once the input register is
// also full, stalls the input.
`include "assert_macros.svh"

module powerpc_branch_next_pc (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction,
  input  logic [63:0] current_pc,
  input  logic [63:0] count_reg,
  input  logic [31:0] cond_reg,
  input  logic [63:0] link_reg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] next_pc,
  output logic        redirected,
  output logic [2:0]  branch_kind
);
  import pbnp_pkg::*;

  logic        s1_valid;
  logic [31:0] s1_instruction;
  logic [63:0] s1_pc;
  logic [63:0] s1_ctr;
  logic [31:0] s1_cr;
  logic [63:0] s1_lr;
  logic        out_ready;
  logic        s1_ready;
  logic        s1_move;
  res_t        res;

  // Stage advance conditions.
  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;
  assign s1_move   = s1_valid && out_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_instruction <= instruction;
      s1_pc          <= current_pc;
      s1_ctr         <= count_reg;
      s1_cr          <= cond_reg;
      s1_lr          <= link_reg;
    end
  end

  // Next-address decode.
  pbnp_resolve u_resolve (
    .instruction (s1_instruction),
    .current_pc  (s1_pc),
    .count_reg   (s1_ctr),
    .cond_reg    (s1_cr),
    .link_reg    (s1_lr),
    .res         (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      next_pc     <= res.next_pc;
      redirected  <= res.redirected;
      branch_kind <= res.kind;
    end
  end

  // Checks.
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!s1_valid && !out_valid), "reset left a beat valid")
  `ASSERT_CLK(a_stall_full, clk, rst, in_stall |-> (s1_valid && out_valid), "input stalled with room")
  `ASSERT_CLK(a_advance, clk, rst, s1_move |=> out_valid, "decoded beat was lost")
  `ASSERT_CLK(a_redir_kind, clk, rst,
    out_valid |-> (redirected == (branch_kind != KIND_SEQ)), "redirect flag disagrees with kind")
  `ASSERT_CLK(a_reg_align, clk, rst,
    (out_valid && (branch_kind == KIND_LINK || branch_kind == KIND_COUNT)) |->
      (next_pc[1:0] == 2'b00), "register target not word aligned")

endmodule
